// ===== sv/cpfa_pkg.sv =====
// cpfa_pkg: shared types and constants of the contiguous page-frame allocator
// used by cpfa_frame_store and contiguous_page_frame_allocator
`default_nettype none

package cpfa_pkg;

   // field widths fixed by the interface
   localparam int COUNT_W = 9;
   localparam int FRAME_W = 20;
   localparam int INDEX_W = 2;

   // configuration register indexes
   localparam logic [INDEX_W-1:0] CSR_FRAME_COUNT     = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_RESERVED_FRAMES = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_BASE_FRAME      = 2'd2;

   // reset values of the configuration registers
   localparam logic [COUNT_W-1:0] FRAME_COUNT_RST     = 9'd256;
   localparam logic [COUNT_W-1:0] RESERVED_FRAMES_RST = 9'd1;
   localparam logic [FRAME_W-1:0] BASE_FRAME_RST      = 20'd0;

   // action codes
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // write controls for the free map and the run length table
   typedef struct packed {
      logic               free_we;
      logic               free_bit;
      logic               len_we;
      logic [COUNT_W-1:0] len_val;
   } store_wr_type;

endpackage

`default_nettype wire

// ===== sv/cpfa_frame_store.sv =====
// cpfa_frame_store: free map and run length table, one read and one write port each
// depends on cpfa_pkg for the write control struct
`default_nettype none

module cpfa_frame_store #(
   parameter int MAX_FRAMES = 256
) (
   input  wire                              clock,
   input  wire  [$clog2(MAX_FRAMES)-1:0]    rd_addr,
   input  wire  [$clog2(MAX_FRAMES)-1:0]    wr_addr,
   input  wire  cpfa_pkg::store_wr_type     wr,
   output logic                             free_q,
   output logic [cpfa_pkg::COUNT_W-1:0]     len_q
);

   logic                         free_mem [MAX_FRAMES];
   logic [cpfa_pkg::COUNT_W-1:0] len_mem  [MAX_FRAMES];

   // free map: one bit per frame, registered read
   always_ff @(posedge clock) begin
      if (wr.free_we) begin
         free_mem[wr_addr] <= wr.free_bit;
      end
      free_q <= free_mem[rd_addr];
   end

   // run length recorded at the first frame of each run
   always_ff @(posedge clock) begin
      if (wr.len_we) begin
         len_mem[wr_addr] <= wr.len_val;
      end
      len_q <= len_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/contiguous_page_frame_allocator.sv =====
// contiguous_page_frame_allocator: first-fit allocator of contiguous page-frame runs
// depends on cpfa_pkg and cpfa_frame_store
//
// Request words carry an action (allocate or free), a page count and a frame
// number; each request gives exactly one response word with granted,
// start_frame and freed_pages. Both channels use valid/stall; a word moves at
// a clock edge with valid high and stall low. The csr_ port writes frame_count,
// reserved_frames and base_frame; the user must write it only while the block
// is idle, and the block itself does not enforce this. One request is handled
// at a time by a sequencer over a shared adder and a frame store with a
// registered read. The scan moves one frame on after a blocked run. req_stall
// stays high from acceptance until the response is loaded into the output
// register; the next request is taken while that response still waits. If
// rsp_stall holds the output register, a finished response waits inside the
// block and req_stall stays high. After reset a clearing pass marks every
// frame free with a zero run length; req_stall is high during it, while csr_
// writes are taken as ever.
`default_nettype none

module contiguous_page_frame_allocator #(
   parameter int MAX_FRAMES = 256
) (
   input  wire                              clock,
   input  wire                              reset,
   // request channel
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_action,
   input  wire  [cpfa_pkg::COUNT_W-1:0]     req_page_count,
   input  wire  [cpfa_pkg::FRAME_W-1:0]     req_frame_number,
   // response channel
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_granted,
   output logic [cpfa_pkg::FRAME_W-1:0]     rsp_start_frame,
   output logic [cpfa_pkg::COUNT_W-1:0]     rsp_freed_pages,
   // configuration write port
   input  wire                              csr_we,
   input  wire  [cpfa_pkg::INDEX_W-1:0]     csr_index,
   input  wire  [cpfa_pkg::FRAME_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(MAX_FRAMES);
   localparam int CW = $clog2(MAX_FRAMES + 1);
   localparam int SW = ((CW > cpfa_pkg::COUNT_W) ? CW : cpfa_pkg::COUNT_W) + 1;
   localparam logic [SW-1:0] MAX_S   = SW'(MAX_FRAMES);
   localparam logic [SW-1:0] MAX_M1  = SW'(MAX_FRAMES - 1);

   // sequencer states
   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_A_HEAD = 4'd2;
   localparam logic [3:0] ST_A_HEVAL= 4'd3;
   localparam logic [3:0] ST_A_PROBE= 4'd4;
   localparam logic [3:0] ST_A_PEVAL= 4'd5;
   localparam logic [3:0] ST_A_MARK = 4'd6;
   localparam logic [3:0] ST_F_RD   = 4'd7;
   localparam logic [3:0] ST_F_EV   = 4'd8;
   localparam logic [3:0] ST_F_REL  = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;

   logic [3:0]                   state_ff, state_in;
   logic [SW-1:0]                i_ff, i_in;
   logic [SW-1:0]                k_ff, k_in;
   logic [cpfa_pkg::COUNT_W-1:0] np_ff, np_in;
   logic [cpfa_pkg::COUNT_W-1:0] len_ff, len_in;
   logic                         res_grant_ff, res_grant_in;
   logic [cpfa_pkg::FRAME_W-1:0] res_start_ff, res_start_in;
   logic [cpfa_pkg::COUNT_W-1:0] res_freed_ff, res_freed_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_granted_ff, rsp_granted_in;
   logic [cpfa_pkg::FRAME_W-1:0] rsp_start_ff, rsp_start_in;
   logic [cpfa_pkg::COUNT_W-1:0] rsp_freed_ff, rsp_freed_in;

   logic [cpfa_pkg::COUNT_W-1:0] fcount_ff;
   logic [cpfa_pkg::COUNT_W-1:0] resv_ff;
   logic [cpfa_pkg::FRAME_W-1:0] base_ff;

   logic [SW-1:0]                fc;
   logic [SW-1:0]                fc_m1;
   logic [SW-1:0]                np_ext;
   logic [SW-1:0]                len_ext;
   logic [SW-1:0]                resv_ext;
   logic [SW-1:0]                addend;
   logic [SW-1:0]                sum;
   logic [SW-1:0]                k_inc;
   logic [cpfa_pkg::FRAME_W-1:0] free_ofs;

   logic [AW-1:0]                rd_addr;
   logic [AW-1:0]                wr_addr;
   cpfa_pkg::store_wr_type       wr;
   logic                         free_q;
   logic [cpfa_pkg::COUNT_W-1:0] len_q;

   logic                         req_take;
   logic                         rsp_take;
   logic                         out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fcount_ff <= cpfa_pkg::FRAME_COUNT_RST;
         resv_ff   <= cpfa_pkg::RESERVED_FRAMES_RST;
         base_ff   <= cpfa_pkg::BASE_FRAME_RST;
      end else if (csr_we) begin
         case (csr_index)
            cpfa_pkg::CSR_FRAME_COUNT:     fcount_ff <= csr_wdata[cpfa_pkg::COUNT_W-1:0];
            cpfa_pkg::CSR_RESERVED_FRAMES: resv_ff   <= csr_wdata[cpfa_pkg::COUNT_W-1:0];
            cpfa_pkg::CSR_BASE_FRAME:      base_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // managed frame count, limited to the map size
   always_comb begin
      fc = (SW'(fcount_ff) > MAX_S) ? MAX_S : SW'(fcount_ff);
   end
   assign fc_m1    = fc - SW'(1);
   assign np_ext   = SW'(np_ff);
   assign len_ext  = SW'(len_ff);
   assign resv_ext = SW'(resv_ff);
   assign k_inc    = k_ff + SW'(1);
   assign free_ofs = req_frame_number - base_ff;

   // shared adder: run end check or frame under test
   assign addend = (state_ff == ST_A_HEVAL) ? np_ext : k_ff;
   assign sum    = i_ff + addend;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // read address: run head or frame under test
   always_comb begin
      case (state_ff)
         ST_A_PROBE: rd_addr = sum[AW-1:0];
         default:    rd_addr = i_ff[AW-1:0];
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      np_in        = np_ff;
      len_in       = len_ff;
      res_grant_in = res_grant_ff;
      res_start_in = res_start_ff;
      res_freed_in = res_freed_ff;
      wr_addr      = sum[AW-1:0];
      wr           = '0;

      rsp_valid_in   = rsp_valid_ff && !rsp_take;
      rsp_granted_in = rsp_granted_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_freed_in   = rsp_freed_ff;

      case (state_ff)
         // sweep the map after reset
         ST_CLEAR: begin
            wr_addr     = i_ff[AW-1:0];
            wr.free_we  = 1'b1;
            wr.free_bit = 1'b1;
            wr.len_we   = 1'b1;
            wr.len_val  = '0;
            if (i_ff == MAX_M1) begin
               state_in = ST_IDLE;
            end else begin
               i_in = i_ff + SW'(1);
            end
         end

         // take a request
         ST_IDLE: begin
            if (req_take) begin
               np_in        = req_page_count;
               k_in         = '0;
               res_grant_in = 1'b0;
               res_start_in = '0;
               res_freed_in = '0;
               if (req_action == cpfa_pkg::ACT_ALLOC) begin
                  i_in     = '0;
                  state_in = ST_A_HEAD;
               end else begin
                  res_grant_in = 1'b1;
                  i_in         = SW'(free_ofs);
                  if (free_ofs < cpfa_pkg::FRAME_W'(fc)) begin
                     state_in = ST_F_RD;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
            end
         end

         // look at the candidate head frame
         ST_A_HEAD: begin
            if (i_ff >= fc) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_A_HEVAL;
            end
         end

         ST_A_HEVAL: begin
            if (!((i_ff >= resv_ext) && free_q)) begin
               if (i_ff == fc_m1) begin
                  state_in = ST_OUT;
               end else begin
                  i_in     = i_ff + SW'(1);
                  state_in = ST_A_HEAD;
               end
            end else if (sum > fc) begin
               state_in = ST_OUT;
            end else begin
               k_in     = SW'(1);
               state_in = ST_A_PROBE;
            end
         end

         // test the rest of the run one frame at a time
         ST_A_PROBE: begin
            if (k_ff >= np_ext) begin
               k_in         = '0;
               res_grant_in = 1'b1;
               res_start_in = base_ff + cpfa_pkg::FRAME_W'(i_ff);
               state_in     = ST_A_MARK;
            end else begin
               state_in = ST_A_PEVAL;
            end
         end

         ST_A_PEVAL: begin
            if ((sum >= resv_ext) && free_q) begin
               k_in     = k_inc;
               state_in = ST_A_PROBE;
            end else begin
               i_in     = i_ff + SW'(1);
               state_in = ST_A_HEAD;
            end
         end

         // claim the run and record its length at the head
         ST_A_MARK: begin
            wr.free_we  = (k_ff < np_ext);
            wr.free_bit = 1'b0;
            wr.len_we   = (k_ff == '0);
            wr.len_val  = np_ff;
            if (k_inc >= np_ext) begin
               state_in = ST_OUT;
            end else begin
               k_in = k_inc;
            end
         end

         // read the recorded run length
         ST_F_RD: begin
            state_in = ST_F_EV;
         end

         ST_F_EV: begin
            len_in       = len_q;
            res_freed_in = len_q;
            k_in         = '0;
            state_in     = ST_F_REL;
         end

         // release the run and clear its length
         ST_F_REL: begin
            wr.free_we  = (k_ff < len_ext) && (sum < MAX_S);
            wr.free_bit = 1'b1;
            wr.len_we   = (k_ff == '0);
            wr.len_val  = '0;
            if ((k_inc >= len_ext) || (sum >= MAX_M1)) begin
               state_in = ST_OUT;
            end else begin
               k_in = k_inc;
            end
         end

         // hand the result to the output register
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_grant_ff;
               rsp_start_in   = res_start_ff;
               rsp_freed_in   = res_freed_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         i_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      np_ff          <= np_in;
      len_ff         <= len_in;
      res_grant_ff   <= res_grant_in;
      res_start_ff   <= res_start_in;
      res_freed_ff   <= res_freed_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_freed_ff   <= rsp_freed_in;
   end

   cpfa_frame_store #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr      (wr),
      .free_q  (free_q),
      .len_q   (len_q)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_start_frame = rsp_start_ff;
   assign rsp_freed_pages = rsp_freed_ff;

   // an accepted request keeps the input closed in the next cycle
   a_req_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request channel stayed open after a request was taken");

   // a failed allocate reports no frame and no release
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> (rsp_start_frame == '0) && (rsp_freed_pages == '0))
      else $error("failed allocate carries a frame or a page count");

   // a response with released pages names no start frame
   a_free_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_freed_pages != '0) |-> rsp_start_frame == '0)
      else $error("free response carries a start frame");

   // claiming never touches a reserved frame
   a_mark_unreserved: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_A_MARK) && wr.free_we |-> sum >= resv_ext)
      else $error("run claim writes into the reserved frames");

   // a finished result waits while the output register is held
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && rsp_valid_ff && rsp_stall |=> state_ff == ST_OUT)
      else $error("result left the sequencer while the output was stalled");

endmodule

`default_nettype wire
